// ===== rtl/core/fixed_point_q24_8_alu_unit_defines.svh =====
// Assertion macros used by the fixed-point ALU top level.
`ifndef FIXED_POINT_Q24_8_ALU_UNIT_DEFINES_SVH
`define FIXED_POINT_Q24_8_ALU_UNIT_DEFINES_SVH

// Check that a condition holds at every edge outside reset.
`define FXA_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("fixed-point ALU check failed");

// Check that a condition implies another one at the same edge.
`define FXA_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fixed-point ALU check failed");

`endif

// ===== rtl/core/fxa_pkg.sv =====
// Shared types and constants of the fixed-point ALU.
package fxa_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_MIN      = 4'd4,
    OP_MAX      = 4'd5,
    OP_INC      = 4'd6,
    OP_DEC      = 4'd7,
    OP_FROM_INT = 4'd8,
    OP_TO_INT   = 4'd9
  } op_t;

  // Sideband that travels beside the divider data.
  typedef struct packed {
    logic [3:0]        op;
    logic [DATA_W-1:0] res;
    logic              lt;
    logic              eq;
    logic              gt;
    logic              dz;
    logic              neg;
  } side_t;

endpackage

// ===== rtl/core/fxa_div_cell.sv =====
// One restoring-division cell: produces one quotient bit per word.
module fxa_div_cell #(
  parameter int W = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  fxa_pkg::side_t  in_side,
  input  logic [W-1:0]    in_rem,
  input  logic [W-1:0]    in_dq,
  input  logic [W-1:0]    in_den,
  output logic            out_valid,
  output fxa_pkg::side_t  out_side,
  output logic [W-1:0]    out_rem,
  output logic [W-1:0]    out_dq,
  output logic [W-1:0]    out_den
);

  logic [W:0] trial;
  logic       fits;

  // Trial subtract of the divisor from the shifted remainder.
  assign trial = {in_rem, in_dq[W-1]} - {1'b0, in_den};
  assign fits  = ~trial[W];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Advance data one cell down the row.
  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      out_den  <= in_den;
      out_rem  <= fits ? trial[W-1:0] : {in_rem[W-2:0], in_dq[W-1]};
      out_dq   <= {in_dq[W-2:0], fits};
    end
  end

endmodule

// ===== rtl/core/fixed_point_q24_8_alu_unit.sv =====
// Top level of the pipelined signed fixed-point ALU.
//  channel | dir | tdata                           | tuser
//  s       | in  | operand_a, operand_b            | req_type
//  m       | out | result_value                    | divide_by_zero, a_greater, a_equal, a_less
// One word is accepted per cycle unless the master side stalls. Each result
// passes through an input stage, one divider cell per quotient bit and an
// output register. Reset clears all valid bits. A stall on the master
// side freezes the whole row and drops s_tready in the same cycle.
`include "fixed_point_q24_8_alu_unit_defines.svh"
module fixed_point_q24_8_alu_unit #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // operand_a [31:0], operand_b [63:32]
  input  logic [3:0]  s_tuser,  // req_type [3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // result_value [31:0]
  output logic [3:0]  m_tuser   // a_less, a_equal, a_greater, divide_by_zero
);

  localparam int DW = fxa_pkg::DATA_W;

  logic en;
  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;

  // Input decode
  logic signed [DW-1:0] a, b, shl, flr, num;
  logic [DW-1:0]        nmag, dmag;
  fxa_pkg::side_t       side_d;

  assign a   = s_tdata[DW-1:0];
  assign b   = s_tdata[2*DW-1:DW];
  assign shl = a <<< FRAC_BITS;
  assign flr = a >>> FRAC_BITS;
  assign num = shl;
  assign nmag = num[DW-1] ? -num : num;
  assign dmag = b[DW-1] ? -b : b;

  always_comb begin
    side_d     = '0;
    side_d.op  = s_tuser;
    side_d.lt  = a < b;
    side_d.eq  = a == b;
    side_d.gt  = a > b;
    side_d.neg = num[DW-1] ^ b[DW-1];
    unique case (s_tuser)
      fxa_pkg::OP_ADD:      side_d.res = a + b;
      fxa_pkg::OP_SUB:      side_d.res = a - b;
      fxa_pkg::OP_DIV:      side_d.dz  = (b == '0);
      fxa_pkg::OP_MIN:      side_d.res = (a <= b) ? a : b;
      fxa_pkg::OP_MAX:      side_d.res = (a >= b) ? a : b;
      fxa_pkg::OP_INC:      side_d.res = a + DW'(1);
      fxa_pkg::OP_DEC:      side_d.res = a - DW'(1);
      fxa_pkg::OP_FROM_INT: side_d.res = shl;
      fxa_pkg::OP_TO_INT:   side_d.res = flr + DW'(a[FRAC_BITS-1]);
      default:              side_d.res = '0;
    endcase
  end

  // Input stage registers
  logic                   v0;
  fxa_pkg::side_t         side0;
  logic signed [2*DW-1:0] prod;
  logic [DW-1:0]          nmag0, dmag0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side0 <= side_d;
      prod  <= a * b;
      nmag0 <= nmag;
      dmag0 <= dmag;
    end
  end

  // Scale the product, truncating toward zero
  logic [2*DW-1:0] pmag, pq, pr;
  fxa_pkg::side_t  side1;

  assign pmag = prod[2*DW-1] ? -prod : prod;
  assign pq   = pmag >> FRAC_BITS;
  assign pr   = prod[2*DW-1] ? -pq : pq;

  always_comb begin
    side1 = side0;
    if (side0.op == fxa_pkg::OP_MUL) begin
      side1.res = pr[DW-1:0];
    end
  end

  // Divider row
  logic           cv [DW+1];
  fxa_pkg::side_t cs [DW+1];
  logic [DW-1:0]  cr [DW+1];
  logic [DW-1:0]  cq [DW+1];
  logic [DW-1:0]  cd [DW+1];

  assign cv[0] = v0;
  assign cs[0] = side1;
  assign cr[0] = '0;
  assign cq[0] = nmag0;
  assign cd[0] = dmag0;

  for (genvar i = 0; i < DW; i++) begin : g_cell
    fxa_div_cell #(.W(DW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(cv[i]), .in_side(cs[i]), .in_rem(cr[i]), .in_dq(cq[i]), .in_den(cd[i]),
      .out_valid(cv[i+1]), .out_side(cs[i+1]), .out_rem(cr[i+1]),
      .out_dq(cq[i+1]), .out_den(cd[i+1])
    );
  end

  // Output register
  fxa_pkg::side_t sl;
  logic [DW-1:0]  qs, res_f;

  assign sl    = cs[DW];
  assign qs    = sl.neg ? -cq[DW] : cq[DW];
  assign res_f = (sl.op == fxa_pkg::OP_DIV) ? (sl.dz ? '0 : qs) : sl.res;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= cv[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= res_f;
      m_tuser <= {sl.dz, sl.gt, sl.eq, sl.lt};
    end
  end

  // Checks
  `FXA_ASSERT_IMPLY(a_flags_onehot, m_tvalid, $onehot(m_tuser[2:0]))
  `FXA_ASSERT_IMPLY(a_dz_zero, m_tvalid && m_tuser[3], m_tdata == '0)
  `FXA_ASSERT_IMPLY(a_stall_blocks, m_tvalid && !m_tready, !s_tready)

endmodule

// ===== tb/sv/fixed_point_q24_8_alu_unit_tb.sv =====
// Self-checking testbench for the Q24.8 fixed-point ALU stream unit.
module fixed_point_q24_8_alu_unit_tb;

  localparam int FRAC = 8;
  localparam int LATENCY = fxa_pkg::DATA_W + 2;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 950;

  typedef struct {
    logic [31:0] value;
    bit          lt;
    bit          eq;
    bit          gt;
    bit          dz;
  } alu_result_t;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    bit          typed;
    logic [31:0] value;
  } alu_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;  // operand_a [31:0], operand_b [63:32]
  logic [3:0]  s_tuser = '0;  // req_type [3:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;       // result_value [31:0]
  logic [3:0]  m_tuser;       // a_less, a_equal, a_greater, divide_by_zero

  alu_result_t result_q[$];
  bit          typed_q[$];
  logic [31:0] typed_val_q[$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          quiet = 1'b0;

  fixed_point_q24_8_alu_unit #(.FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #2 clk = ~clk;

  task automatic report(input string msg);
    $display("mismatch @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Compute the ALU result of one word
  function automatic alu_result_t alu_compute(logic [3:0] op, logic [31:0] ua, logic [31:0] ub);
    alu_result_t r;
    longint      a;
    longint      b;
    longint      p;
    longint      num;
    longint unsigned q;
    a = longint'(signed'(ua));
    b = longint'(signed'(ub));
    r.value = '0;
    r.dz = 1'b0;
    r.lt = a < b;
    r.eq = a == b;
    r.gt = a > b;
    case (op)
      fxa_pkg::OP_ADD: r.value = ua + ub;
      fxa_pkg::OP_SUB: r.value = ua - ub;
      fxa_pkg::OP_MUL: begin
        p = a * b;
        q = (p < 0) ? longint'(-p) : p;
        q = q >> FRAC;
        if (p < 0) q = -q;
        r.value = q[31:0];
      end
      fxa_pkg::OP_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          num = longint'(signed'(ua << FRAC));
          q = longint'((num < 0) ? -num : num) / longint'((b < 0) ? -b : b);
          if ((num < 0) != (b < 0)) q = -q;
          r.value = q[31:0];
        end
      end
      fxa_pkg::OP_MIN: r.value = (a <= b) ? ua : ub;
      fxa_pkg::OP_MAX: r.value = (a >= b) ? ua : ub;
      fxa_pkg::OP_INC: r.value = ua + 1;
      fxa_pkg::OP_DEC: r.value = ua - 1;
      fxa_pkg::OP_FROM_INT: r.value = ua << FRAC;
      fxa_pkg::OP_TO_INT: begin
        p = a >>> FRAC;
        if (ua[FRAC-1]) p = p + 1;
        r.value = p[31:0];
      end
      default: r.value = '0;
    endcase
    return r;
  endfunction

  // Track handshakes on both sides and check results
  always @(posedge clk) begin
    alu_result_t exp_r;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (!rst && s_tvalid && s_tready) begin
      exp_r = alu_compute(s_tuser, s_tdata[31:0], s_tdata[63:32]);
      if (typed_q.size() > 0 && typed_q.pop_front()) exp_r.value = typed_val_q.pop_front();
      else if (typed_val_q.size() > 0) void'(typed_val_q.pop_front());
      result_q.push_back(exp_r);
    end
    if (!rst && m_tvalid && m_tready) begin
      if (result_q.size() == 0) begin
        report("result word with nothing pending");
      end else begin
        exp_r = result_q.pop_front();
        if (m_tdata !== exp_r.value)
          report($sformatf("value %h, want %h", m_tdata, exp_r.value));
        if (m_tuser[0] !== exp_r.lt) report("a_less flag wrong");
        if (m_tuser[1] !== exp_r.eq) report("a_equal flag wrong");
        if (m_tuser[2] !== exp_r.gt) report("a_greater flag wrong");
        if (m_tuser[3] !== exp_r.dz) report("divide_by_zero flag wrong");
      end
    end
  end

  // Stall the result side in random bursts
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (quiet || $urandom_range(0, 3) != 0) begin
        m_tready <= 1'b1;
        n = $urandom_range(1, 30);
      end else begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 10);
      end
      repeat (n - 1) @(posedge clk);
    end
  end

  // Present one word and hold it until taken
  task automatic send_word(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b,
                           input bit typed, input logic [31:0] value);
    typed_q.push_back(typed);
    typed_val_q.push_back(value);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {b, a};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'(signed'($urandom_range(0, 2048)) - 1024);
      5: return 32'h100 * $urandom_range(0, 16);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    alu_row_t rows[$];
    logic [3:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    rows = '{
      '{fxa_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h1, 1'b1, 32'h8000_0000},
      '{fxa_pkg::OP_SUB, 32'h8000_0000, 32'h1, 1'b1, 32'h7FFF_FFFF},
      '{fxa_pkg::OP_MUL, 32'h100, 32'h100, 1'b1, 32'h100},
      '{fxa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0},
      '{fxa_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h1, 1'b1, 32'h0},
      '{fxa_pkg::OP_DIV, 32'h100, 32'h0, 1'b1, 32'h0},
      '{fxa_pkg::OP_DIV, 32'h0080_0000, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000},
      '{fxa_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h3, 1'b0, 32'h0},
      '{fxa_pkg::OP_DIV, 32'h200, 32'h100, 1'b1, 32'h200},
      '{fxa_pkg::OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000},
      '{fxa_pkg::OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
      '{fxa_pkg::OP_MIN, 32'h5, 32'h5, 1'b1, 32'h5},
      '{fxa_pkg::OP_INC, 32'hFFFF_FFFF, 32'h0, 1'b1, 32'h0},
      '{fxa_pkg::OP_INC, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000},
      '{fxa_pkg::OP_DEC, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      '{fxa_pkg::OP_FROM_INT, 32'h0080_0000, 32'h0, 1'b1, 32'h8000_0000},
      '{fxa_pkg::OP_FROM_INT, 32'hFFFF_FFFF, 32'h0, 1'b1, 32'hFFFF_FF00},
      '{fxa_pkg::OP_TO_INT, 32'h180, 32'h0, 1'b1, 32'h2},
      '{fxa_pkg::OP_TO_INT, 32'hFFFF_FF80, 32'h0, 1'b1, 32'h0},
      '{fxa_pkg::OP_TO_INT, 32'h7FFF_FFFF, 32'h0, 1'b1, 32'h0080_0000},
      '{fxa_pkg::OP_TO_INT, 32'h8000_0000, 32'h0, 1'b1, 32'hFF80_0000},
      '{4'd10, 32'h1234, 32'h1, 1'b1, 32'h0},
      '{4'd15, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 32'h0}
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Walk the directed table
    foreach (rows[i]) send_word(rows[i].op, rows[i].a, rows[i].b, rows[i].typed, rows[i].value);
    // Random words; calm last stretch
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - 100) quiet = 1'b1;
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
      a = pick_operand();
      b = (op == fxa_pkg::OP_DIV && $urandom_range(0, 7) == 0) ? 32'h0 : pick_operand();
      if ($urandom_range(0, 9) == 0) b = a;
      send_word(op, a, b, 1'b0, 32'h0);
    end
    s_tvalid <= 1'b0;
    while (result_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 16) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
